// ===== src/rtc_pkg.sv =====
// Shared types, codes and character classes for the route template checker.
// No dependencies.
`timescale 1ns / 1ps

package rtc_pkg;

  typedef enum logic [2:0] {
    PH_ROOT   = 3'd0,
    PH_SLASH  = 3'd1,
    PH_STATIC = 3'd2,
    PH_VOPEN  = 3'd3,
    PH_VBODY  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_SKIP       = 3'd0,
    ROLE_SLASH      = 3'd1,
    ROLE_STAT_FIRST = 3'd2,
    ROLE_STAT_CHAR  = 3'd3,
    ROLE_OPEN       = 3'd4,
    ROLE_VAR_CHAR   = 3'd5,
    ROLE_CLOSE      = 3'd6
  } role_e;

  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_BRACE_MID   = 3'd1,
    ERR_STAT_AFTER  = 3'd2,
    ERR_BAD_STATIC  = 3'd3,
    ERR_BAD_VAR     = 3'd4,
    ERR_NO_CLOSE    = 3'd5
  } err_e;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  typedef struct packed {
    phase_e phase;
    logic   var_seen;
    err_e   err;
  } state_t;

  // Result item as carried on the output stream, lowest field last here.
  typedef struct packed {
    logic       last;
    err_e       err;
    logic [7:0] char_out;
    role_e      role;
  } result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_letter_digit(input logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

// ===== src/rtc_step.sv =====
// Per-character decode: next parser state, role and sticky error.
// Depends on rtc_pkg.
`timescale 1ns / 1ps

module rtc_step (
  input  rtc_pkg::state_t state_i,
  input  logic [7:0]      char_i,
  input  logic            last_i,
  output rtc_pkg::state_t state_o,
  output rtc_pkg::role_e  role_o
);

  rtc_pkg::phase_e phase_n;
  rtc_pkg::role_e  role_n;
  rtc_pkg::err_e   err_n;
  logic            var_n;

  always_comb begin
    phase_n = state_i.phase;
    role_n  = rtc_pkg::ROLE_SKIP;
    err_n   = rtc_pkg::ERR_OK;
    var_n   = state_i.var_seen;
    case (state_i.phase)
      rtc_pkg::PH_SLASH: begin
        if (char_i == rtc_pkg::CH_OPEN) begin
          role_n  = rtc_pkg::ROLE_OPEN;
          phase_n = rtc_pkg::PH_VOPEN;
          var_n   = 1'b1;
        end else if (state_i.var_seen) begin
          err_n = rtc_pkg::ERR_STAT_AFTER;
        end else if (rtc_pkg::is_letter(char_i)) begin
          role_n  = rtc_pkg::ROLE_STAT_FIRST;
          phase_n = rtc_pkg::PH_STATIC;
        end else begin
          err_n = rtc_pkg::ERR_BAD_STATIC;
        end
      end
      rtc_pkg::PH_STATIC: begin
        if (char_i == rtc_pkg::CH_SLASH) begin
          role_n  = rtc_pkg::ROLE_SLASH;
          phase_n = rtc_pkg::PH_SLASH;
        end else if (rtc_pkg::is_letter_digit(char_i)) begin
          role_n = rtc_pkg::ROLE_STAT_CHAR;
        end else begin
          err_n = rtc_pkg::ERR_BAD_STATIC;
        end
      end
      rtc_pkg::PH_VOPEN: begin
        if (rtc_pkg::is_letter(char_i)) begin
          role_n  = rtc_pkg::ROLE_VAR_CHAR;
          phase_n = rtc_pkg::PH_VBODY;
        end else begin
          err_n = rtc_pkg::ERR_BAD_VAR;
        end
      end
      rtc_pkg::PH_VBODY: begin
        if (char_i == rtc_pkg::CH_CLOSE) begin
          role_n  = rtc_pkg::ROLE_CLOSE;
          phase_n = rtc_pkg::PH_ROOT;
        end else if (rtc_pkg::is_letter_digit(char_i)) begin
          role_n = rtc_pkg::ROLE_VAR_CHAR;
        end else begin
          err_n = rtc_pkg::ERR_BAD_VAR;
        end
      end
      default: begin
        // root; also covers phase codes that never occur
        if (char_i == rtc_pkg::CH_SLASH) begin
          role_n  = rtc_pkg::ROLE_SLASH;
          phase_n = rtc_pkg::PH_SLASH;
        end else if (char_i == rtc_pkg::CH_OPEN) begin
          err_n = rtc_pkg::ERR_BRACE_MID;
        end
      end
    endcase
  end

  always_comb begin
    state_o = state_i;
    role_o  = rtc_pkg::ROLE_SKIP;
    // once an error is held, nothing moves until the path ends
    if (state_i.err == rtc_pkg::ERR_OK) begin
      state_o.phase    = phase_n;
      state_o.var_seen = var_n;
      if (err_n != rtc_pkg::ERR_OK) begin
        state_o.err = err_n;
      end else begin
        role_o = role_n;
        if (last_i && (phase_n == rtc_pkg::PH_VOPEN || phase_n == rtc_pkg::PH_VBODY)) begin
          state_o.err = rtc_pkg::ERR_NO_CLOSE;
        end
      end
    end
  end

endmodule

// ===== src/rtc_out_buf.sv =====
// Two-entry output buffer (output register plus skid) for result items.
// Depends on rtc_pkg.
`timescale 1ns / 1ps

module rtc_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rtc_pkg::result_t data_i,
  output logic             ready_o,
  output logic             valid_o,
  output rtc_pkg::result_t data_o,
  input  logic             pop_ready_i
);

  logic             out_vld_q, out_vld_d;
  logic             skid_vld_q, skid_vld_d;
  rtc_pkg::result_t out_q, out_d;
  rtc_pkg::result_t skid_q, skid_d;
  logic             pop;

  assign pop     = out_vld_q && pop_ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      // no push possible while the skid entry is full
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_d     = data_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = data_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_vld_q |-> out_vld_q)
    else $error("skid entry full while output register empty");

endmodule

// ===== src/route_template_checker.sv =====
// Top level of the route template checker: parser state and output buffer.
// Depends on rtc_pkg, rtc_step and rtc_out_buf.
`timescale 1ns / 1ps

// Usage
//   Input stream: one template byte per request on s_axis_tdata, the final
//   byte of a path flagged by s_axis_tlast. Output stream: one result per
//   byte with its role, the echoed byte and the running error code; tlast
//   copies the input flag and then the error code is final for the path.
//   Throughput: one byte per cycle while s_axis_tready is high. The parser
//   state update is a single level of decode from the accepted byte, so a
//   new byte can follow in every cycle unless the output buffer is full.
//   Results: a result is registered in the output buffer as its byte is accepted.
//   Stall: results sit in a two-entry buffer (output register plus skid);
//   while the output is stalled one more byte is still taken, then
//   s_axis_tready drops until the receiver takes a result.
//   Reset: the parser returns to root, no variable seen, no error, and the
//   output buffer is empty. The same parser state is restored after every
//   byte marked last.
//   An error is held from the byte that raises it to the end of the path;
//   those bytes carry role skipped, but for ERR_NO_CLOSE on the last byte.

module route_template_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_in
  input  logic        s_axis_tlast,  // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [2:0] role, [10:3] char_out, [13:11] error_code
  output logic        m_axis_tlast   // path_done
);

  localparam rtc_pkg::state_t StateReset = '{
    phase:    rtc_pkg::PH_ROOT,
    var_seen: 1'b0,
    err:      rtc_pkg::ERR_OK
  };

  rtc_pkg::state_t  state_q, state_d, step_state;
  rtc_pkg::role_e   step_role;
  rtc_pkg::result_t res, out_res;
  logic             in_acc;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  rtc_step u_step (
    .state_i (state_q),
    .char_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .state_o (step_state),
    .role_o  (step_role)
  );

  always_comb begin
    state_d = state_q;
    if (in_acc) begin
      state_d = s_axis_tlast ? StateReset : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    res.role     = step_role;
    res.char_out = s_axis_tdata;
    res.err      = step_state.err;
    res.last     = s_axis_tlast;
  end

  rtc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .data_i      (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (out_res),
    .pop_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {2'b00, out_res.err, out_res.char_out, out_res.role};
  assign m_axis_tlast = out_res.last;

  // end of path always brings the parser back to its reset state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast |=> state_q == StateReset)
    else $error("parser state not cleared after last byte");

  // a held error does not change within a path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tlast && state_q.err != rtc_pkg::ERR_OK
    |=> state_q.err == $past(state_q.err))
    else $error("sticky error changed mid-path");

  // bytes under a parse error are reported as skipped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_res.err != rtc_pkg::ERR_OK && out_res.err != rtc_pkg::ERR_NO_CLOSE
    |-> out_res.role == rtc_pkg::ROLE_SKIP)
    else $error("non-skip role reported under a parse error");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for route_template_checker: directed table, then random paths.
// Depends on rtc_pkg and route_template_checker; results are checked against an in-bench model.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_ITEMS   = 1950;
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    rtc_pkg::role_e role;
    logic [7:0]     chr;
    rtc_pkg::err_e  err;
    logic           done;
  } route_result_t;

  typedef struct {
    logic [7:0]     chr;
    logic           last;
    logic           fixed;
    rtc_pkg::role_e role;
    rtc_pkg::err_e  err;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  route_result_t expected_q[$];
  logic [7:0]    path_bytes[$];

  // parser state mirrored by the bench
  rtc_pkg::phase_e path_phase = rtc_pkg::PH_ROOT;
  logic            path_var   = 1'b0;
  rtc_pkg::err_e   path_err   = rtc_pkg::ERR_OK;

  int  mismatches = 0;
  int  accepted   = 0;
  int  idle_cycles = 0;
  bit  no_idle    = 1'b0;

  // fixed rows carry their expected role and error; others use the predictor
  dir_row_t dir_rows [26] = '{
    '{8'h00, 1'b0, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"/",   1'b0, 1'b1, rtc_pkg::ROLE_SLASH, rtc_pkg::ERR_OK},
    '{"a",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"9",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"/",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"{",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"Z",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"}",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{8'hFF, 1'b1, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"{",   1'b0, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_BRACE_MID},
    '{"a",   1'b1, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_BRACE_MID},
    '{"/",   1'b1, 1'b1, rtc_pkg::ROLE_SLASH, rtc_pkg::ERR_OK},
    '{"/",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"{",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"x",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"}",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"/",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"b",   1'b1, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_STAT_AFTER},
    '{"/",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"k",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{8'h80, 1'b1, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_BAD_STATIC},
    '{"/",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"{",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"9",   1'b1, 1'b1, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_BAD_VAR},
    '{"/",   1'b0, 1'b0, rtc_pkg::ROLE_SKIP,  rtc_pkg::ERR_OK},
    '{"{",   1'b1, 1'b1, rtc_pkg::ROLE_OPEN,  rtc_pkg::ERR_NO_CLOSE}
  };

  route_template_checker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic ascii_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic ascii_alnum(input logic [7:0] c);
    return ascii_alpha(c) || (c >= "0" && c <= "9");
  endfunction

  // Role and running error for one byte; advances the mirrored parser state.
  function automatic route_result_t classify_byte(input logic [7:0] c, input logic last);
    route_result_t r;
    rtc_pkg::err_e raised;
    r.role = rtc_pkg::ROLE_SKIP;
    r.chr  = c;
    r.done = last;
    raised = rtc_pkg::ERR_OK;
    if (path_err == rtc_pkg::ERR_OK) begin
      case (path_phase)
        rtc_pkg::PH_SLASH: begin
          if (c == rtc_pkg::CH_OPEN) begin
            r.role = rtc_pkg::ROLE_OPEN;
            path_phase = rtc_pkg::PH_VOPEN;
            path_var = 1'b1;
          end else if (path_var) begin
            raised = rtc_pkg::ERR_STAT_AFTER;
          end else if (ascii_alpha(c)) begin
            r.role = rtc_pkg::ROLE_STAT_FIRST;
            path_phase = rtc_pkg::PH_STATIC;
          end else begin
            raised = rtc_pkg::ERR_BAD_STATIC;
          end
        end
        rtc_pkg::PH_STATIC: begin
          if (c == rtc_pkg::CH_SLASH) begin
            r.role = rtc_pkg::ROLE_SLASH;
            path_phase = rtc_pkg::PH_SLASH;
          end else if (ascii_alnum(c)) begin
            r.role = rtc_pkg::ROLE_STAT_CHAR;
          end else begin
            raised = rtc_pkg::ERR_BAD_STATIC;
          end
        end
        rtc_pkg::PH_VOPEN: begin
          if (ascii_alpha(c)) begin
            r.role = rtc_pkg::ROLE_VAR_CHAR;
            path_phase = rtc_pkg::PH_VBODY;
          end else begin
            raised = rtc_pkg::ERR_BAD_VAR;
          end
        end
        rtc_pkg::PH_VBODY: begin
          if (c == rtc_pkg::CH_CLOSE) begin
            r.role = rtc_pkg::ROLE_CLOSE;
            path_phase = rtc_pkg::PH_ROOT;
          end else if (ascii_alnum(c)) begin
            r.role = rtc_pkg::ROLE_VAR_CHAR;
          end else begin
            raised = rtc_pkg::ERR_BAD_VAR;
          end
        end
        default: begin
          if (c == rtc_pkg::CH_SLASH) begin
            r.role = rtc_pkg::ROLE_SLASH;
            path_phase = rtc_pkg::PH_SLASH;
          end else if (c == rtc_pkg::CH_OPEN) begin
            raised = rtc_pkg::ERR_BRACE_MID;
          end
        end
      endcase
      if (raised != rtc_pkg::ERR_OK) begin
        path_err = raised;
        r.role = rtc_pkg::ROLE_SKIP;
      end else if (last && (path_phase == rtc_pkg::PH_VOPEN ||
                            path_phase == rtc_pkg::PH_VBODY)) begin
        path_err = rtc_pkg::ERR_NO_CLOSE;
      end
    end
    r.err = path_err;
    if (last) begin
      path_phase = rtc_pkg::PH_ROOT;
      path_var = 1'b0;
      path_err = rtc_pkg::ERR_OK;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] c;
    c = 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? "A" + c : "a" + c;
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 3) == 0) return "0" + 8'($urandom_range(0, 9));
    return rand_letter();
  endfunction

  // any byte that the root phase just skips
  function automatic logic [7:0] rand_skip();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == rtc_pkg::CH_SLASH || c == rtc_pkg::CH_OPEN);
    return c;
  endfunction

  function automatic void add_byte(input logic [7:0] c);
    path_bytes.insert(path_bytes.size(), c);
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic last, input logic fixed,
                           input rtc_pkg::role_e role, input rtc_pkg::err_e err);
    int            gap;
    route_result_t want;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    want = classify_byte(c, last);
    if (fixed) begin
      want.role = role;
      want.err  = err;
    end
    expected_q.insert(expected_q.size(), want);
    accepted++;
  endtask

  // Mostly well-formed templates with random content; some corrupted or plain noise.
  task automatic build_path();
    int  nseg;
    int  n;
    int  idx;
    bit  var_open;
    path_bytes.delete();
    if ($urandom_range(0, 99) < 75) begin
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) add_byte(rand_skip());
      nseg = $urandom_range(0, 4);
      var_open = 1'b0;
      repeat (nseg) begin
        add_byte(rtc_pkg::CH_SLASH);
        if (!var_open && $urandom_range(0, 1)) begin
          add_byte(rand_letter());
          repeat ($urandom_range(0, 5)) add_byte(rand_alnum());
        end else begin
          var_open = 1'b1;
          add_byte(rtc_pkg::CH_OPEN);
          add_byte(rand_letter());
          repeat ($urandom_range(0, 4)) add_byte(rand_alnum());
          add_byte(rtc_pkg::CH_CLOSE);
          repeat ($urandom_range(0, 2)) add_byte(rand_skip());
        end
      end
      if ($urandom_range(0, 4) == 0) add_byte(rtc_pkg::CH_SLASH);
      if (path_bytes.size() == 0) add_byte(rand_skip());
      if ($urandom_range(0, 99) < 20) begin
        idx = $urandom_range(0, path_bytes.size() - 1);
        path_bytes[idx] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(1, path_bytes.size());
        while (path_bytes.size() > n) void'(path_bytes.pop_back());
      end
    end else begin
      repeat ($urandom_range(1, 10)) begin
        case ($urandom_range(0, 5))
          0:       add_byte(rtc_pkg::CH_SLASH);
          1:       add_byte(rtc_pkg::CH_OPEN);
          2:       add_byte(rtc_pkg::CH_CLOSE);
          3:       add_byte(rand_letter());
          4:       add_byte(rand_alnum());
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h actual %0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    route_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: unexpected result, expected none actual %0h", $realtime, m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("role", 8'(want.role), 8'(m_axis_tdata[2:0]));
        check_field("char_out", want.chr, m_axis_tdata[10:3]);
        check_field("error_code", 8'(want.err), 8'(m_axis_tdata[13:11]));
        check_field("path_done", 8'(want.done), 8'(m_axis_tlast));
        check_field("tdata pad", 8'h00, 8'(m_axis_tdata[15:14]));
      end
    end
  end

  // watchdog: cycles with no request taken on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off so the input side backs up
  initial begin : receiver
    int  stall;
    bit  held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && accepted >= 600) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k])
      send_byte(dir_rows[k].chr, dir_rows[k].last, dir_rows[k].fixed,
                dir_rows[k].role, dir_rows[k].err);

    while (accepted < NUM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      build_path();
      for (i = 0; i < path_bytes.size(); i++)
        send_byte(path_bytes[i], i == path_bytes.size() - 1, 1'b0,
                  rtc_pkg::ROLE_SKIP, rtc_pkg::ERR_OK);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
